// File: design/dhkv_pkg.sv
// shared types and constants for the double hash key value table
package dhkv_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int VALUE_BITS_DEF  = 32;

	localparam int CFG_W     = 7;
	localparam int KLEN_W    = 4;
	localparam int KEY_W     = 64;
	localparam int VAL_IN_W  = 32;
	localparam int STATUS_W  = 3;
	localparam int TOTAL_W   = 7;
	localparam int TDATA_IN_W  = 104;
	localparam int TDATA_OUT_W = 48;

	localparam logic [CFG_W-1:0] BUCKETS_RESET = 7'd53;

	localparam logic [7:0] MUL_A = 8'd151;
	localparam logic [7:0] MUL_B = 8'd163;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_NOP    = 2'd3;

	localparam logic [1:0] MARK_EMPTY   = 2'd0;
	localparam logic [1:0] MARK_LIVE    = 2'd1;
	localparam logic [1:0] MARK_DELETED = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;

endpackage

// File: design/double_hash_key_value_table_top.sv
// double hash key value table: sequencer, shared modulo unit, bucket memory
// One request at a time. After the accepting edge each key byte takes two hash
// steps (a multiply-add state, then a mod unit that subtracts one shifted
// multiple of the bucket count per cycle), then a step-size state, then the
// first probe (memory read, decide) and each further probe (address add, reduce,
// read, decide). A NOP skips all of these. The result waits in an output
// register until taken, and the block is ready again the cycle after. The slot
// marks are cleared by a sweep over all TABLE_DEPTH slots after reset, during
// which no request is accepted.
module double_hash_key_value_table_top #(
	parameter int TABLE_DEPTH = dhkv_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BYTES   = dhkv_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS  = dhkv_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dhkv_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// req_type[1:0], key_bytes[65:2], key_length[69:66], value_in[101:70]
	input  logic [dhkv_pkg::TDATA_IN_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[2:0], value_out[34:3], entry_total[41:35]
	output logic [dhkv_pkg::TDATA_OUT_W-1:0]  m_tdata
);
	import dhkv_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int KB_W   = $clog2(KEY_BYTES + 1);
	localparam int KBI_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int KEYS_W = 8 * KEY_BYTES;
	// operand of the mod unit: below 2^(CFG_W+8+1)
	localparam int MOD_W  = CFG_W + 9;
	localparam int SH_W   = $clog2(MOD_W);
	localparam logic [CFG_W-1:0] DEPTH_C = CFG_W'(TABLE_DEPTH > 127 ? 127 : TABLE_DEPTH);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_HMUL   = 4'd2;
	localparam logic [3:0] S_HMOD   = 4'd3;
	localparam logic [3:0] S_STEP   = 4'd4;
	localparam logic [3:0] S_PADDR  = 4'd5;
	localparam logic [3:0] S_PMOD   = 4'd6;
	localparam logic [3:0] S_PREAD  = 4'd7;
	localparam logic [3:0] S_PCHK   = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0]              state_q;
	logic [CFG_W-1:0]        buckets_q;
	logic [CNT_W-1:0]        live_q;
	logic [IDX_W-1:0]        clr_q;

	logic [1:0]              mark_mem [TABLE_DEPTH];
	logic [KEYS_W-1:0]       key_mem  [TABLE_DEPTH];
	logic [KB_W-1:0]         klen_mem [TABLE_DEPTH];
	logic [VALUE_BITS-1:0]   val_mem  [TABLE_DEPTH];

	logic [1:0]              req_q;
	logic [KEYS_W-1:0]       key_q;
	logic [KB_W-1:0]         len_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [CFG_W-1:0]        m_q;
	logic [KBI_W-1:0]        bi_q;
	logic                    hsel_q;
	logic [CFG_W-1:0]        ha_q, hb_q, step_q, pos_q;
	logic [CNT_W-1:0]        pn_q;
	logic [MOD_W-1:0]        mod_q;
	logic [SH_W-1:0]         msh_q;
	logic [1:0]              rmark_q;
	logic [KEYS_W-1:0]       rkey_q;
	logic [KB_W-1:0]         rklen_q;
	logic [VALUE_BITS-1:0]   rval_q;
	logic [IDX_W-1:0]        ridx_q;
	logic [STATUS_W-1:0]     st_q;
	logic [VALUE_BITS-1:0]   vout_q;

	// input unpack
	logic [1:0]              in_req;
	logic [KEY_W-1:0]        in_key;
	logic [KLEN_W-1:0]       in_len;
	logic [VAL_IN_W-1:0]     in_val;
	logic [KB_W-1:0]         len_c;
	logic [KEYS_W-1:0]       key_mask;
	logic [CFG_W-1:0]        m_c;

	assign in_req = s_tdata[1:0];
	assign in_key = s_tdata[65:2];
	assign in_len = s_tdata[69:66];
	assign in_val = s_tdata[101:70];

	always_comb begin
		if (in_len > KLEN_W'(KEY_BYTES)) begin
			len_c = KB_W'(KEY_BYTES);
		end else begin
			len_c = KB_W'(in_len);
		end
		for (int i = 0; i < KEY_BYTES; i++) begin
			key_mask[8*i +: 8] = (KB_W'(i) < len_c) ? 8'hff : 8'h00;
		end
		if (buckets_q == '0) begin
			m_c = CFG_W'(1);
		end else if (buckets_q > DEPTH_C) begin
			m_c = DEPTH_C;
		end else begin
			m_c = buckets_q;
		end
	end

	// shared mod unit: restoring subtract of m shifted by msh_q
	logic [MOD_W-1:0]        msub;
	logic [MOD_W-1:0]        mod_next;
	assign msub = MOD_W'(m_q) << msh_q;
	assign mod_next = (mod_q >= msub) ? (mod_q - msub) : mod_q;

	logic [7:0]              cur_byte;
	logic [CFG_W-1:0]        hcur;
	logic [7:0]              mul_c;
	logic [MOD_W-1:0]        hmul;
	assign cur_byte = key_q[8*bi_q +: 8];
	assign hcur = hsel_q ? hb_q : ha_q;
	assign mul_c = hsel_q ? MUL_B : MUL_A;
	assign hmul = MOD_W'(hcur) * MOD_W'(mul_c) + MOD_W'(cur_byte);

	logic key_hit;
	assign key_hit = (rmark_q == MARK_LIVE) && (rklen_q == len_q) && (rkey_q == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			buckets_q <= BUCKETS_RESET;
			live_q    <= '0;
			clr_q     <= '0;
		end else begin
			if (cfg_we) begin
				buckets_q <= cfg_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						ha_q    <= '0;
						hb_q    <= '0;
						bi_q    <= '0;
						hsel_q  <= 1'b0;
						pn_q    <= '0;
						req_q   <= in_req;
						len_q   <= len_c;
						key_q   <= in_key[KEYS_W-1:0] & key_mask;
						val_q   <= VALUE_BITS'(in_val);
						m_q     <= m_c;
						st_q    <= ST_NOT_FOUND;
						vout_q  <= '0;
						if (in_req == REQ_NOP) begin
							state_q <= S_OUT;
						end else if (len_c == '0) begin
							state_q <= S_STEP;
						end else begin
							state_q <= S_HMUL;
						end
					end
				end
				S_HMUL: begin
					mod_q   <= hmul;
					msh_q   <= SH_W'(MOD_W - CFG_W);
					state_q <= S_HMOD;
				end
				S_HMOD: begin
					mod_q <= mod_next;
					msh_q <= msh_q - 1'b1;
					if (msh_q == '0) begin
						if (hsel_q) begin
							hb_q <= CFG_W'(mod_next);
						end else begin
							ha_q <= CFG_W'(mod_next);
						end
						hsel_q <= ~hsel_q;
						if (hsel_q) begin
							if (KB_W'(bi_q) == len_q - 1'b1) begin
								state_q <= S_STEP;
							end else begin
								bi_q    <= bi_q + 1'b1;
								state_q <= S_HMUL;
							end
						end else begin
							state_q <= S_HMUL;
						end
					end
				end
				S_STEP: begin
					// hb + 1 below 2m, one compare and subtract
					if (CFG_W'(hb_q + 1'b1) >= m_q) begin
						step_q <= CFG_W'(hb_q + 1'b1 - m_q);
					end else begin
						step_q <= CFG_W'(hb_q + 1'b1);
					end
					pos_q   <= ha_q;
					state_q <= S_PREAD;
				end
				S_PADDR: begin
					mod_q   <= MOD_W'(pos_q) + MOD_W'(step_q);
					msh_q   <= '0;
					state_q <= S_PMOD;
				end
				S_PMOD: begin
					pos_q   <= CFG_W'(mod_next);
					state_q <= S_PREAD;
				end
				S_PREAD: begin
					ridx_q  <= IDX_W'(pos_q);
					rmark_q <= mark_mem[IDX_W'(pos_q)];
					rkey_q  <= key_mem[IDX_W'(pos_q)];
					rklen_q <= klen_mem[IDX_W'(pos_q)];
					rval_q  <= val_mem[IDX_W'(pos_q)];
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (req_q == REQ_INSERT) begin
						if (rmark_q != MARK_LIVE) begin
							live_q  <= live_q + 1'b1;
							st_q    <= ST_INSERTED;
							state_q <= S_OUT;
						end else if (pn_q == CNT_W'(m_q - 1'b1)) begin
							st_q    <= ST_FULL;
							state_q <= S_OUT;
						end else begin
							pn_q    <= pn_q + 1'b1;
							state_q <= S_PADDR;
						end
					end else begin
						if (rmark_q == MARK_EMPTY) begin
							state_q <= S_OUT;
						end else if (key_hit) begin
							if (req_q == REQ_SEARCH) begin
								st_q   <= ST_FOUND;
								vout_q <= rval_q;
							end else begin
								st_q <= ST_REMOVED;
								if (live_q != '0) begin
									live_q <= live_q - 1'b1;
								end
							end
							state_q <= S_OUT;
						end else if (pn_q == CNT_W'(m_q - 1'b1)) begin
							state_q <= S_OUT;
						end else begin
							pn_q    <= pn_q + 1'b1;
							state_q <= S_PADDR;
						end
					end
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// bucket memory writes
	logic ins_wr, del_wr;
	assign ins_wr = (state_q == S_PCHK) && (req_q == REQ_INSERT) && (rmark_q != MARK_LIVE);
	assign del_wr = (state_q == S_PCHK) && (req_q == REQ_REMOVE) &&
		(rmark_q != MARK_EMPTY) && key_hit;

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			mark_mem[clr_q] <= MARK_EMPTY;
		end else if (ins_wr) begin
			mark_mem[ridx_q] <= MARK_LIVE;
		end else if (del_wr) begin
			mark_mem[ridx_q] <= MARK_DELETED;
		end
		if (ins_wr) begin
			key_mem[ridx_q]  <= key_q;
			klen_mem[ridx_q] <= len_q;
			val_mem[ridx_q]  <= val_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);

	always_comb begin
		m_tdata = '0;
		m_tdata[2:0]   = st_q;
		m_tdata[34:3]  = VAL_IN_W'(vout_q);
		m_tdata[41:35] = TOTAL_W'(live_q);
	end

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CNT_W'(TABLE_DEPTH))
		else $error("live count above depth");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("accept while result pending");
	a_found_val: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && st_q != ST_FOUND) |-> (vout_q == '0))
		else $error("value out nonzero without a hit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped while stalled");

endmodule

// File: tb/double_hash_key_value_table_top_test.sv
// testbench for the double hash key value table: directed and random requests, self checking
`timescale 1ns / 100ps

module double_hash_key_value_table_top_test;
	import dhkv_pkg::*;

	localparam int DEPTH      = TABLE_DEPTH_DEF;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [31:0]         value;
		logic [TOTAL_W-1:0]  total;
	} answer_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [TDATA_IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;

	// table mirror
	logic [1:0]  mark_q [DEPTH];
	logic [63:0] key_q [DEPTH];
	logic [3:0]  len_q [DEPTH];
	logic [31:0] val_q [DEPTH];
	int unsigned live_total;
	logic [CFG_W-1:0] buckets_reg;

	answer_t answers_due[$];
	int errors;
	int requests_sent;
	int answers_seen;
	int full_seen;
	int found_seen;
	int idle_cycles;
	int stall_left;

	// key pool so searches and removes hit stored entries
	logic [63:0] pool_key [12];
	logic [3:0]  pool_len [12];

	double_hash_key_value_table_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	function automatic int unsigned horner_sum(logic [63:0] k, int unsigned n,
			int unsigned mul, int unsigned m);
		int unsigned h;
		h = 0;
		for (int i = 0; i < n; i++)
			h = (h * mul + k[8*i +: 8]) % m;
		return h;
	endfunction

	// expected answer for one request, updates the mirror
	function automatic answer_t table_update(logic [1:0] req, logic [63:0] kin,
			logic [3:0] lin, logic [31:0] vin);
		answer_t a;
		int unsigned m, n_len, home, step, idx;
		logic [63:0] k;
		m = buckets_reg;
		if (m == 0) m = 1;
		if (m > DEPTH) m = DEPTH;
		n_len = (lin > 8) ? 8 : lin;
		k = (n_len == 8) ? kin : (kin & ((64'd1 << (8*n_len)) - 64'd1));
		home = horner_sum(k, n_len, 151, m);
		step = horner_sum(k, n_len, 163, m) + 1;
		a.status = ST_NOT_FOUND;
		a.value = '0;
		if (req == REQ_INSERT) begin
			a.status = ST_FULL;
			for (int unsigned n = 0; n < m; n++) begin
				idx = (home + n * step) % m;
				if (mark_q[idx] != MARK_LIVE) begin
					mark_q[idx] = MARK_LIVE;
					key_q[idx] = k;
					len_q[idx] = 4'(n_len);
					val_q[idx] = vin;
					live_total++;
					a.status = ST_INSERTED;
					break;
				end
			end
		end else if (req == REQ_SEARCH || req == REQ_REMOVE) begin
			for (int unsigned n = 0; n < m; n++) begin
				idx = (home + n * step) % m;
				if (mark_q[idx] == MARK_EMPTY) break;
				if (mark_q[idx] == MARK_LIVE && len_q[idx] == n_len && key_q[idx] == k) begin
					if (req == REQ_SEARCH) begin
						a.status = ST_FOUND;
						a.value = val_q[idx];
					end else begin
						mark_q[idx] = MARK_DELETED;
						if (live_total > 0) live_total--;
						a.status = ST_REMOVED;
					end
					break;
				end
			end
		end
		a.total = live_total[TOTAL_W-1:0];
		return a;
	endfunction

	// valid stays high from one transaction to the next unless idle is called
	task automatic send_request(logic [1:0] req, logic [63:0] k, logic [3:0] len,
			logic [31:0] v);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, v, len, k, req};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		answers_due.push_back(table_update(req, k, len, v));
		requests_sent++;
	endtask

	task automatic idle(int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		idle(0);
		while (answers_due.size() != 0) @(posedge clk);
		// sequencer is done once its answer has gone out
		repeat (4) @(negedge clk);
	endtask

	task automatic write_buckets(logic [CFG_W-1:0] b);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= b;
		buckets_reg = b;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_buckets();
		logic [63:0] ones;
		ones = '1;
		send_request(REQ_SEARCH, 64'h0, 4'd0, 32'h0);
		send_request(REQ_INSERT, 64'h0, 4'd0, 32'h0000_0001);
		send_request(REQ_SEARCH, 64'hffff_ffff_ffff_ff00, 4'd0, 32'hffff_ffff);
		send_request(REQ_INSERT, ones, 4'd8, 32'hffff_ffff);
		// long length clamps to eight bytes
		send_request(REQ_SEARCH, ones, 4'd15, 32'h0);
		send_request(REQ_SEARCH, ones, 4'd7, 32'h0);
		send_request(REQ_INSERT, 64'hdead_beef_0000_4161, 4'd2, 32'h1234_5678);
		send_request(REQ_SEARCH, 64'h0000_0000_0000_4161, 4'd2, 32'h0);
		send_request(REQ_NOP, ones, 4'd8, 32'h0);
		send_request(REQ_REMOVE, ones, 4'd8, 32'h0);
		send_request(REQ_REMOVE, ones, 4'd8, 32'h0);
		send_request(REQ_SEARCH, ones, 4'd8, 32'h0);
		send_request(REQ_SEARCH, 64'h0, 4'd0, 32'h0);
	endtask

	task automatic test_bucket_extremes();
		write_buckets(7'd1);
		send_request(REQ_INSERT, 64'h55, 4'd1, 32'haaaa_5555);
		send_request(REQ_INSERT, 64'h66, 4'd1, 32'h1);
		send_request(REQ_SEARCH, 64'h55, 4'd1, 32'h0);
		send_request(REQ_REMOVE, 64'h55, 4'd1, 32'h0);
		send_request(REQ_INSERT, 64'h66, 4'd1, 32'h2);
		write_buckets(7'd0);
		send_request(REQ_SEARCH, 64'h66, 4'd1, 32'h0);
		send_request(REQ_INSERT, 64'h77, 4'd1, 32'h3);
		write_buckets(7'd127);
		send_request(REQ_INSERT, 64'h0123_4567_89ab_cdef, 4'd8, 32'h8000_0000);
		send_request(REQ_SEARCH, 64'h0123_4567_89ab_cdef, 4'd8, 32'h0);
		write_buckets(7'd64);
		send_request(REQ_SEARCH, 64'h0123_4567_89ab_cdef, 4'd8, 32'h0);
	endtask

	task automatic test_random_phase(logic [CFG_W-1:0] b, int count);
		int r, p;
		logic [1:0] req;
		logic [63:0] k;
		logic [3:0] len;
		write_buckets(b);
		for (int i = 0; i < 12; i++) begin
			pool_key[i] = {$urandom, $urandom};
			pool_len[i] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) :
				4'($urandom_range(0, 8));
		end
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) req = REQ_INSERT;
			else if (r < 72) req = REQ_SEARCH;
			else if (r < 96) req = REQ_REMOVE;
			else req = REQ_NOP;
			p = $urandom_range(0, 11);
			if ($urandom_range(0, 9) < 8) begin
				// same stored key, junk above its length
				k = pool_key[p];
				if (pool_len[p] < 8) k = k | ({$urandom, $urandom} << (8 * pool_len[p]));
				len = pool_len[p];
			end else begin
				k = {$urandom, $urandom};
				len = 4'($urandom_range(0, 15));
			end
			send_request(req, k, len, $urandom);
			r = rand_gap();
			if (r > 0) idle(r);
		end
	endtask

	// result side stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 15) stall_left <= rand_gap();
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (m_tvalid && m_tready) begin
			answers_seen++;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h", $time, m_tdata);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (m_tdata[2:0] == ST_FULL) full_seen++;
				if (m_tdata[2:0] == ST_FOUND) found_seen++;
				if (m_tdata[2:0] !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[34:3] !== want.value) begin
					$display("%0t: value expected %h actual %h", $time, want.value,
						m_tdata[34:3]);
					errors++;
				end
				if (m_tdata[41:35] !== want.total) begin
					$display("%0t: entry total expected %0d actual %0d", $time, want.total,
						m_tdata[41:35]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		errors = 0;
		requests_sent = 0;
		answers_seen = 0;
		full_seen = 0;
		found_seen = 0;
		idle_cycles = 0;
		stall_left = 0;
		live_total = 0;
		buckets_reg = BUCKETS_RESET;
		for (int i = 0; i < DEPTH; i++) begin
			mark_q[i] = MARK_EMPTY;
			key_q[i] = '0;
			len_q[i] = '0;
			val_q[i] = '0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_reset_buckets();
		test_bucket_extremes();
		test_random_phase(7'd53, 220);
		test_random_phase(7'd5, 200);
		test_random_phase(7'd64, 240);
		test_random_phase(7'd2, 180);
		test_random_phase(7'd127, 220);
		test_random_phase(7'd17, 220);
		test_random_phase(7'd0, 150);
		test_random_phase(7'($urandom_range(1, 63)), 300);

		drain();
		repeat (50) @(posedge clk);
		$display("%0d requests over bucket counts 0 to 127, %0d answers checked", requests_sent,
			answers_seen);
		$display("%0d found, %0d table full answers", found_seen, full_seen);
		if (errors == 0 && answers_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
